### rtl/rbst_pkg.sv
// Shared constants for the ray / box slab hit test.
// No dependencies.
`default_nettype none
package rbst_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int EPS_WIDTH       = 31;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);
  localparam int NUM_AXES = 3;
  localparam int NUM_DIVS = 2 * NUM_AXES;
endpackage
`default_nettype wire

### rtl/ray_box_slab_test.sv
// Pipelined ray / axis-aligned box hit test using the slab method.
// Depends on rbst_pkg.
//
// Usage: drive the twelve coordinate ports and pulse start; an item is
// accepted at each rising edge with start high and busy low. busy is high
// only during reset, so one item per cycle is taken otherwise.
// Results: hit is valid in the one cycle that done is high. Results leave in
// the order items entered.
// Throughput is one item per cycle: the six slab quotients come from six
// restoring dividers with one quotient bit per register stage
// (COORD_WIDTH + 1 + FRAC_BITS stages), followed by a sign stage, an x/y
// interval merge stage and the z compare at the output register.
// direction_epsilon is written when eps_we is high; it resets to 1 and is
// sampled as the item passes the input register.
// Reset (rst, synchronous) clears all valid bits; items in flight are dropped.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
module ray_box_slab_test #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire logic eps_we,
  input  wire logic [rbst_pkg::EPS_WIDTH-1:0] direction_epsilon,
  input  wire logic signed [COORD_WIDTH-1:0] origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] dir_z,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_z,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_z,
  output logic done,
  output logic hit
);
  import rbst_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NB  = W + 1 + FRAC_BITS;
  localparam int EW  = ((W > EPS_WIDTH) ? W : EPS_WIDTH) + 2;
  localparam logic signed [W-1:0] T_CAP = {1'b0, {(W-1){1'b1}}};

  logic [EPS_WIDTH-1:0] eps;

  // input register
  logic va;
  logic signed [W-1:0] oa [NUM_AXES];
  logic signed [W-1:0] da [NUM_AXES];
  logic signed [W-1:0] la [NUM_AXES];
  logic signed [W-1:0] ha [NUM_AXES];
  logic [EPS_WIDTH-1:0] epsa;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
      va  <= 1'b0;
    end else begin
      if (eps_we) eps <= direction_epsilon;
      va <= start;
    end
    epsa  <= eps;
    oa[0] <= origin_x;  oa[1] <= origin_y;  oa[2] <= origin_z;
    da[0] <= dir_x;     da[1] <= dir_y;     da[2] <= dir_z;
    la[0] <= box_min_x; la[1] <= box_min_y; la[2] <= box_min_z;
    ha[0] <= box_max_x; ha[1] <= box_max_y; ha[2] <= box_max_z;
  end

  // setup: inside / away tests, numerators and denominators
  logic inside_c, away_c;
  logic [NUM_AXES-1:0] par_c;
  logic [NUM_DIVS-1:0] sgn_c;
  logic [W:0]   mag_c [NUM_DIVS];
  logic [W-1:0] den_c [NUM_DIVS];

  always_comb begin
    logic signed [EW-1:0] de, ee;
    logic signed [W:0] ow, bi, bo, di, dx;
    logic lt, gt, pos, neg, dneg;
    logic [W:0] dm;
    inside_c = 1'b1;
    away_c   = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      lt = oa[k] < la[k];
      gt = oa[k] > ha[k];
      dneg = da[k][W-1];
      if (lt || gt) inside_c = 1'b0;
      if ((lt && (dneg || da[k] == '0)) || (gt && !dneg)) away_c = 1'b1;
      de = EW'(da[k]);
      ee = EW'(epsa);
      pos = de > ee;
      neg = de < -ee;
      par_c[k] = !pos && !neg;
      ow = (W+1)'(oa[k]);
      bi = neg ? (W+1)'(ha[k]) : (W+1)'(la[k]);
      bo = neg ? (W+1)'(la[k]) : (W+1)'(ha[k]);
      di = bi - ow;
      dx = bo - ow;
      mag_c[2*k]   = di[W] ? (W+1)'(-di) : (W+1)'(di);
      mag_c[2*k+1] = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
      sgn_c[2*k]   = di[W] ^ dneg;
      sgn_c[2*k+1] = dx[W] ^ dneg;
      dm = dneg ? (W+1)'(-((W+1)'(da[k]))) : (W+1)'(da[k]);
      den_c[2*k]   = dm[W-1:0];
      den_c[2*k+1] = dm[W-1:0];
    end
  end

  // divider pipeline, index 0 is the setup register
  logic                v    [0:NB];
  logic                ins  [0:NB];
  logic                awy  [0:NB];
  logic [NUM_AXES-1:0] par  [0:NB];
  logic [NUM_DIVS-1:0] sgn  [0:NB];
  logic [W-1:0]  rem [0:NB][NUM_DIVS];
  logic [W-1:0]  den [0:NB][NUM_DIVS];
  logic [W-1:0]  q   [0:NB][NUM_DIVS];
  logic          sat [0:NB][NUM_DIVS];
  logic [NB-1:0] num [0:NB][NUM_DIVS];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= va;
    ins[0] <= inside_c;
    awy[0] <= away_c;
    par[0] <= par_c;
    sgn[0] <= sgn_c;
    for (int j = 0; j < NUM_DIVS; j++) begin
      rem[0][j] <= '0;
      q[0][j]   <= '0;
      sat[0][j] <= 1'b0;
      den[0][j] <= den_c[j];
      num[0][j] <= NB'(mag_c[j]) << FRAC_BITS;
    end
  end

  for (genvar s = 1; s <= NB; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [W:0] r2;
      logic ge;
      if (rst) v[s] <= 1'b0;
      else     v[s] <= v[s-1];
      ins[s] <= ins[s-1];
      awy[s] <= awy[s-1];
      par[s] <= par[s-1];
      sgn[s] <= sgn[s-1];
      for (int j = 0; j < NUM_DIVS; j++) begin
        r2 = {rem[s-1][j], num[s-1][j][NB-1]};
        ge = r2 >= {1'b0, den[s-1][j]};
        rem[s][j] <= ge ? W'(r2 - {1'b0, den[s-1][j]}) : r2[W-1:0];
        q[s][j]   <= {q[s-1][j][W-2:0], ge};
        sat[s][j] <= sat[s-1][j] | q[s-1][j][W-1];
        den[s][j] <= den[s-1][j];
        num[s][j] <= num[s-1][j] << 1;
      end
    end
  end

  // sign and saturate
  logic vt, inst, awyt;
  logic signed [W-1:0] t [NUM_DIVS];

  always_ff @(posedge clk) begin
    logic [W-1:0] m;
    if (rst) vt <= 1'b0;
    else     vt <= v[NB];
    inst <= ins[NB];
    awyt <= awy[NB];
    for (int j = 0; j < NUM_DIVS; j++) begin
      m = (sat[NB][j] || q[NB][j][W-1]) ? T_CAP : q[NB][j];
      if (par[NB][j/2]) t[j] <= (j % 2 == 0) ? '0 : T_CAP;
      else              t[j] <= sgn[NB][j] ? -$signed(m) : $signed(m);
    end
  end

  // merge x and y
  logic vm, insm, awym, missm;
  logic signed [W-1:0] t0m, t1m, t2m, t3m;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else     vm <= vt;
    insm  <= inst;
    awym  <= awyt;
    missm <= (t[2] >= t[1]) || (t[3] <= t[0]);
    t0m   <= (t[2] < t[0]) ? t[0] : t[2];
    t1m   <= (t[3] < t[1]) ? t[3] : t[1];
    t2m   <= t[4];
    t3m   <= t[5];
  end

  // z compare and output
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vm;
    hit <= insm || (!awym && !missm && !((t2m >= t1m) || (t3m <= t0m)));
  end

  a_lat : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, NB + 5))
    else $error("result without matching item");
  a_inside : assert property (@(posedge clk) disable iff (rst)
    (v[0] && ins[0]) |-> ##(NB + 3) (done && hit))
    else $error("origin inside box but no hit");
  a_rst : assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");
endmodule
`default_nettype wire
